>>> rtl/lmks_pkg.sv
// ----------------------------------------------------------------------------
// lmks_pkg
// Shared types, constants and the key code table for the LED multiplexer
// with key matrix scan.
// ----------------------------------------------------------------------------
package lmks_pkg;

   localparam int NUM_DIGITS_DEF = 9;
   localparam int KEY_ROWS_DEF   = 6;

   localparam int TICK_W         = 14;
   localparam int SLOW_FOLD_W    = 11;
   localparam int FAST_WRAP_W    = 13;
   localparam int SLOW_BLINK_BIT = 9;
   localparam int FAST_BLINK_BIT = 11;
   localparam logic [SLOW_FOLD_W-1:0] SLOW_WRAP = 11'h7ff;

   localparam int DWELL_W = 8;
   localparam logic [DWELL_W-1:0] DWELL_RESET    = 8'h40;
   localparam logic [DWELL_W-1:0] DWELL_HELD     = 8'h0e;
   localparam logic [DWELL_W-1:0] DWELL_RELEASE  = 8'h0d;
   localparam logic [DWELL_W-1:0] DWELL_LIT_STEP = 8'h10;

   localparam int BLINK_W   = 9;
   localparam int DIGIT_W   = 4;
   localparam int SEG_W     = 8;
   localparam int LEVELS_W  = 8;
   localparam int ROW_W     = 3;
   localparam int CODE_W    = 8;

   localparam int KEY_IDX_W      = 7;
   localparam int KEY_TABLE_SIZE = 112;
   localparam logic [KEY_IDX_W-1:0] ALT_OFFSET = 7'(7 * 8);

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SLOW_MODE  = 2'd0,
      CSR_ALT_LAYOUT = 2'd1,
      CSR_BLINK_MASK = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic               valid;
      logic [DIGIT_W-1:0] digit;
      logic [SEG_W-1:0]   segments;
   } light_type;

   typedef struct packed {
      logic             valid;
      logic [ROW_W-1:0] row;
      logic [ROW_W-1:0] column;
   } scan_type;

   typedef struct packed {
      logic              valid;
      logic [CODE_W-1:0] code;
   } key_type;

   localparam logic [CODE_W-1:0] KEY_TABLE [KEY_TABLE_SIZE] = '{
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h22, 8'h29, 8'h28, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h24, 8'h11, 8'h12, 8'h13, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h23, 8'h14, 8'h15, 8'h16, 8'h26, 8'h00, 8'h00, 8'h00,
      8'h17, 8'h18, 8'h19, 8'h25, 8'h27, 8'h21, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h22, 8'h29, 8'h28, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h24, 8'h11, 8'h12, 8'h13, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h23, 8'h14, 8'h15, 8'h16, 8'h25, 8'h00, 8'h00, 8'h00,
      8'h17, 8'h18, 8'h19, 8'h26, 8'h27, 8'h21, 8'h00, 8'h00,
      8'h11, 8'h23, 8'h13, 8'hff, 8'h00, 8'h00, 8'h12, 8'h00
   };

endpackage

>>> rtl/lmks_tick.sv
// ----------------------------------------------------------------------------
// lmks_tick
// Tick counter, advanced only on its advance input, with speed-dependent wrap and blink phase.
// ----------------------------------------------------------------------------
module lmks_tick
   import lmks_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  logic slow_mode,
   output logic blink_on
);

   logic [TICK_W-1:0]    tick_ff;
   logic [TICK_W-1:0]    tick_in;
   logic [TICK_W-1:0]    tick_inc;
   logic [TICK_W-1:0]    tick_next;
   logic [SLOW_FOLD_W:0] fold_sum;
   logic                 fold_zero;
   logic                 wrap;

   // 2048 is 1 modulo 2047: fold the high bits onto the low ones
   always_comb begin
      tick_inc  = tick_ff + TICK_W'(1);
      fold_sum  = {1'b0, tick_inc[SLOW_FOLD_W-1:0]}
                + (SLOW_FOLD_W+1)'(tick_inc[TICK_W-1:SLOW_FOLD_W]);
      fold_zero = (fold_sum == '0) || (fold_sum == {1'b0, SLOW_WRAP});
      wrap      = (slow_mode && fold_zero) || (tick_inc[FAST_WRAP_W-1:0] == '0);
      tick_next = wrap ? '0 : tick_inc;
      tick_in   = advance ? tick_next : tick_ff;
      blink_on  = slow_mode ? tick_next[SLOW_BLINK_BIT] : tick_next[FAST_BLINK_BIT];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= '0;
      end else begin
         tick_ff <= tick_in;
      end
   end

endmodule

>>> rtl/lmks_display.sv
// ----------------------------------------------------------------------------
// lmks_display
// Digit pattern store and digit sequencer; picks the next digit to light
// and its lit dwell.
// ----------------------------------------------------------------------------
module lmks_display
   import lmks_pkg::*;
#(
   parameter int NUM_DIGITS = NUM_DIGITS_DEF
)(
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  logic [DIGIT_W-1:0] wr_digit,
   input  logic [SEG_W-1:0]   wr_pattern,
   input  logic               step,
   input  logic               blink_on,
   input  logic [BLINK_W-1:0] blink_mask,
   output light_type          light,
   output logic [DWELL_W-1:0] lit_dwell
);

   localparam int IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

   logic [SEG_W-1:0]   patterns_ff [NUM_DIGITS];
   logic [IDX_W-1:0]   digit_pos_ff;
   logic [IDX_W-1:0]   digit_pos_in;
   logic [IDX_W:0]     pos_inc;
   logic [DIGIT_W-1:0] pos_wide;
   logic               blinked;
   logic               show;
   logic [SEG_W-1:0]   seg;
   logic [DIGIT_W-1:0] seg_ones;
   logic               wr_hit;

   always_comb begin
      pos_wide  = DIGIT_W'(digit_pos_ff);
      blinked   = (pos_wide < DIGIT_W'(BLINK_W)) ? blink_mask[pos_wide] : 1'b0;
      show      = !blinked || blink_on;
      seg       = patterns_ff[digit_pos_ff];
      seg_ones  = DIGIT_W'($countones(seg));
      lit_dwell = {seg_ones + DIGIT_W'(1), 4'h1};

      light.valid    = step && show;
      light.digit    = light.valid ? pos_wide : '0;
      light.segments = light.valid ? seg : '0;

      pos_inc      = {1'b0, digit_pos_ff} + (IDX_W+1)'(1);
      digit_pos_in = digit_pos_ff;
      if (step) begin
         digit_pos_in = (pos_inc >= (IDX_W+1)'(NUM_DIGITS)) ? '0 : pos_inc[IDX_W-1:0];
      end

      wr_hit = wr_en && ({1'b0, wr_digit} < 5'(NUM_DIGITS));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_pos_ff <= '0;
         for (int i = 0; i < NUM_DIGITS; i++) begin
            patterns_ff[i] <= '0;
         end
      end else begin
         digit_pos_ff <= digit_pos_in;
         if (wr_hit) begin
            patterns_ff[wr_digit[IDX_W-1:0]] <= wr_pattern;
         end
      end
   end

endmodule

>>> rtl/lmks_scan.sv
// ----------------------------------------------------------------------------
// lmks_scan
// Dwell timer and triangular key matrix probe with release detection.
// ----------------------------------------------------------------------------
module lmks_scan
   import lmks_pkg::*;
#(
   parameter int KEY_ROWS = KEY_ROWS_DEF
)(
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic [LEVELS_W-1:0] levels,
   input  logic                alt_layout,
   input  logic                load_valid,
   input  logic [DWELL_W-1:0]  load_dwell,
   output logic                dark_done,
   output scan_type            scan,
   output key_type             key
);

   localparam logic [ROW_W-1:0] ROW_START = ROW_W'(KEY_ROWS);

   logic [DWELL_W-1:0]   dwell_ff;
   logic [DWELL_W-1:0]   dwell_in;
   logic [ROW_W-1:0]     row_ff;
   logic [ROW_W-1:0]     row_in;
   logic [ROW_W-1:0]     col_ff;
   logic [ROW_W-1:0]     col_in;

   logic                 lit_active;
   logic [DWELL_W-1:0]   dwell_lit;
   logic                 hold;
   logic                 probe;
   logic [DWELL_W-1:0]   dwell_dark;
   logic [ROW_W-1:0]     col_dec;
   logic [ROW_W-1:0]     row_dec;
   logic                 pressed;
   logic                 released;
   logic [KEY_IDX_W-1:0] key_idx;
   logic [CODE_W-1:0]    code;
   logic [ROW_W-1:0]     col_after;
   logic [DWELL_W-1:0]   dwell_probe;

   always_comb begin
      lit_active = dwell_ff[7:4] != '0;
      dwell_lit  = lit_active ? dwell_ff - DWELL_LIT_STEP : dwell_ff;
      hold       = lit_active && (dwell_lit[7:4] != '0);
      probe      = !hold && (dwell_lit != '0);
      dark_done  = !hold && (dwell_lit == '0);

      dwell_dark = dwell_lit - DWELL_W'(1);
      col_dec    = col_ff - ROW_W'(1);
      row_dec    = row_ff - ROW_W'(1);
      pressed    = levels[col_dec];
      released   = !pressed && (dwell_dark == DWELL_RELEASE);
      key_idx    = KEY_IDX_W'({row_dec, col_dec}) + (alt_layout ? ALT_OFFSET : '0);
      code       = (key_idx < KEY_IDX_W'(KEY_TABLE_SIZE)) ? KEY_TABLE[key_idx] : '0;
      col_after  = pressed ? col_ff : col_dec;
      dwell_probe = pressed ? DWELL_HELD : dwell_dark;

      scan.valid  = probe;
      scan.row    = probe ? row_ff : '0;
      scan.column = probe ? col_dec : '0;
      key.valid   = probe && released;
      key.code    = (probe && released) ? code : '0;

      dwell_in = dwell_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      if (advance) begin
         if (hold) begin
            dwell_in = dwell_lit;
         end else if (probe) begin
            dwell_in = dwell_probe;
            col_in   = col_after;
            if (col_after == '0) begin
               if (row_dec != '0) begin
                  row_in = row_dec;
                  col_in = row_dec;
               end else begin
                  row_in = ROW_START;
                  col_in = ROW_START;
               end
            end
         end else begin
            dwell_in = load_valid ? load_dwell : dwell_lit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dwell_ff <= DWELL_RESET;
         row_ff   <= ROW_START;
         col_ff   <= ROW_START;
      end else begin
         dwell_ff <= dwell_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
      end
   end

endmodule

>>> rtl/led_mux_with_key_matrix_scan_top.sv
// ----------------------------------------------------------------------------
// led_mux_with_key_matrix_scan_top
// Multiplexed LED digit driver with key matrix probing in the dark periods.
// An accepted item is registered in the input register, then its result in
// the result register. Throughput: one item per cycle unless rsp_stall holds
// the result; the tick and dwell update is one short pass between the input
// register and the result register. Reset clears the pattern store, the tick
// counter, the digit position and all configuration registers, loads the
// dwell timer with 0x40 and parks the probe at row and column KEY_ROWS.
// ----------------------------------------------------------------------------
module led_mux_with_key_matrix_scan_top
   import lmks_pkg::*;
#(
   parameter int NUM_DIGITS = NUM_DIGITS_DEF,
   parameter int KEY_ROWS   = KEY_ROWS_DEF
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_mode,
   input  logic [LEVELS_W-1:0]   req_column_levels,
   input  logic [DIGIT_W-1:0]    req_write_digit,
   input  logic [SEG_W-1:0]      req_write_pattern,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_light_valid,
   output logic [DIGIT_W-1:0]    rsp_lit_digit,
   output logic [SEG_W-1:0]      rsp_lit_segments,
   output logic                  rsp_scan_valid,
   output logic [ROW_W-1:0]      rsp_scan_row,
   output logic [ROW_W-1:0]      rsp_scan_column,
   output logic                  rsp_key_valid,
   output logic [CODE_W-1:0]     rsp_key_code,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic               slow_mode_ff;
   logic               alt_layout_ff;
   logic [BLINK_W-1:0] blink_mask_ff;

   logic                in_valid_ff;
   logic                in_valid_in;
   logic                in_mode_ff;
   logic [LEVELS_W-1:0] in_levels_ff;
   logic [DIGIT_W-1:0]  in_digit_ff;
   logic [SEG_W-1:0]    in_pattern_ff;

   logic                out_valid_ff;
   logic                out_valid_in;
   light_type           out_light_ff;
   light_type           out_light_in;
   scan_type            out_scan_ff;
   scan_type            out_scan_in;
   key_type             out_key_ff;
   key_type             out_key_in;

   logic               accept;
   logic               advance;
   logic               fire;
   logic               tick_fire;
   logic               write_fire;
   logic               blink_on;
   logic               dark_done;
   logic [DWELL_W-1:0] lit_dwell;
   light_type          light;
   scan_type           scan;
   key_type            key;

   always_comb begin
      advance     = !out_valid_ff || !rsp_stall;
      req_stall   = in_valid_ff && !advance;
      accept      = req_valid && !req_stall;
      fire        = in_valid_ff && advance;
      tick_fire   = fire && !in_mode_ff;
      write_fire  = fire && in_mode_ff;
      in_valid_in = accept || (in_valid_ff && !advance);

      out_valid_in = fire || (out_valid_ff && rsp_stall);
      out_light_in = '0;
      out_scan_in  = '0;
      out_key_in   = '0;
      if (!in_mode_ff) begin
         out_light_in = light;
         out_scan_in  = scan;
         out_key_in   = key;
      end
   end

   lmks_tick u_tick (
      .clock     (clock),
      .reset     (reset),
      .advance   (tick_fire),
      .slow_mode (slow_mode_ff),
      .blink_on  (blink_on)
   );

   lmks_scan #(
      .KEY_ROWS (KEY_ROWS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .advance    (tick_fire),
      .levels     (in_levels_ff),
      .alt_layout (alt_layout_ff),
      .load_valid (light.valid),
      .load_dwell (lit_dwell),
      .dark_done  (dark_done),
      .scan       (scan),
      .key        (key)
   );

   lmks_display #(
      .NUM_DIGITS (NUM_DIGITS)
   ) u_display (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (write_fire),
      .wr_digit   (in_digit_ff),
      .wr_pattern (in_pattern_ff),
      .step       (tick_fire && dark_done),
      .blink_on   (blink_on),
      .blink_mask (blink_mask_ff),
      .light      (light),
      .lit_dwell  (lit_dwell)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         slow_mode_ff  <= 1'b0;
         alt_layout_ff <= 1'b0;
         blink_mask_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SLOW_MODE:  slow_mode_ff  <= csr_wdata[0];
            CSR_ALT_LAYOUT: alt_layout_ff <= csr_wdata[0];
            CSR_BLINK_MASK: blink_mask_ff <= csr_wdata[BLINK_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_mode_ff    <= req_mode;
         in_levels_ff  <= req_column_levels;
         in_digit_ff   <= req_write_digit;
         in_pattern_ff <= req_write_pattern;
      end
      if (fire) begin
         out_light_ff <= out_light_in;
         out_scan_ff  <= out_scan_in;
         out_key_ff   <= out_key_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_light_valid  = out_light_ff.valid;
   assign rsp_lit_digit    = out_light_ff.digit;
   assign rsp_lit_segments = out_light_ff.segments;
   assign rsp_scan_valid   = out_scan_ff.valid;
   assign rsp_scan_row     = out_scan_ff.row;
   assign rsp_scan_column  = out_scan_ff.column;
   assign rsp_key_valid    = out_key_ff.valid;
   assign rsp_key_code     = out_key_ff.code;

endmodule

>>> rtl/lmks_checker.sv
// ----------------------------------------------------------------------------
// lmks_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module lmks_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_light_valid,
   input logic [3:0] rsp_lit_digit,
   input logic [7:0] rsp_lit_segments,
   input logic       rsp_scan_valid,
   input logic [2:0] rsp_scan_row,
   input logic [2:0] rsp_scan_column,
   input logic       rsp_key_valid,
   input logic [7:0] rsp_key_code
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_key_code)
         && $stable(rsp_lit_segments) && $stable(rsp_scan_column))
      else $error("result changed while stalled");

   a_light_or_scan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_light_valid && rsp_scan_valid))
      else $error("digit lit and key probed in the same tick");

   a_key_needs_probe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_key_valid |-> rsp_scan_valid)
      else $error("key release without a probe");

   a_probe_triangle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_scan_valid |-> rsp_scan_row != 3'd0
         && rsp_scan_column < rsp_scan_row)
      else $error("probe position outside the row and column walk");

   a_idle_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_light_valid && !rsp_key_valid |->
         rsp_lit_digit == 4'd0 && rsp_lit_segments == 8'd0 && rsp_key_code == 8'd0)
      else $error("unflagged result fields not zero");

endmodule

bind led_mux_with_key_matrix_scan_top lmks_checker u_lmks_checker (.*);
